// File: design/serial_frame_builder_crc32_macros.svh
// assertion macros shared by the frame builder rtl
`ifndef SERIAL_FRAME_BUILDER_CRC32_MACROS_SVH
`define SERIAL_FRAME_BUILDER_CRC32_MACROS_SVH

// same-cycle implication, checked out of reset
`define SFB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfb same-cycle check failed");

// next-cycle implication, checked out of reset
`define SFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfb next-cycle check failed");

`endif

// File: design/sfb_pkg.sv
// types, codes and crc helper for the frame builder
package sfb_pkg;

  localparam int unsigned BURST_DEPTH = 8;
  localparam int unsigned BURST_IDX_W = 3;
  localparam int unsigned CFG_IDX_W   = 1;

  localparam logic CMD_START   = 1'b0;
  localparam logic CMD_PAYLOAD = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC_SECOND = 1'b1;

  localparam logic [1:0] ERR_NONE           = 2'd0;
  localparam logic [1:0] ERR_BYTE_OUTSIDE   = 2'd1;
  localparam logic [1:0] ERR_START_IN_FRAME = 2'd2;

  localparam logic [31:0] CRC_SEED = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // one item's worth of output bytes plus the flags that go with them
  typedef struct packed {
    logic [BURST_DEPTH-1:0][7:0] bytes;
    logic [BURST_IDX_W-1:0]      last_idx;
    logic                        trailer;
    logic [1:0]                  err;
  } burst_t;

  // reflected crc-32, one byte per call, unrolled into an xor network
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'h0);
    end
    return c;
  endfunction

endpackage

// File: design/sfb_burst.sv
// output burst register: holds one item's bytes and sends one per cycle unless stalled
module sfb_burst (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  sfb_pkg::burst_t      desc,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_frame_end,
  output logic [1:0]           out_error_code,
  output logic                 out_run_last
);

  logic                               valid_r, valid_nxt;
  logic [sfb_pkg::BURST_IDX_W-1:0]    rd_r, rd_nxt;
  sfb_pkg::burst_t                    desc_r, desc_nxt;
  logic                               take;
  logic                               at_last;

  assign take    = valid_r && !out_stall;
  assign at_last = (rd_r == desc_r.last_idx);
  assign free    = !valid_r || (take && at_last);

  always_comb begin
    valid_nxt = valid_r;
    rd_nxt    = rd_r;
    desc_nxt  = desc_r;
    if (load) begin
      valid_nxt = 1'b1;
      rd_nxt    = '0;
      desc_nxt  = desc;
    end else if (take) begin
      if (at_last) begin
        valid_nxt = 1'b0;
      end else begin
        rd_nxt = rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rd_r    <= '0;
    end else begin
      valid_r <= valid_nxt;
      rd_r    <= rd_nxt;
    end
    desc_r <= desc_nxt;
  end

  assign out_valid      = valid_r;
  assign out_byte       = desc_r.bytes[rd_r];
  assign out_frame_end  = desc_r.trailer && at_last;
  assign out_error_code = desc_r.err;
  assign out_run_last   = at_last;

endmodule

// File: design/serial_frame_builder_crc32.sv
// top level of the length-prefixed frame builder with crc-32 trailer
// A start item (cmd 0) opens a frame: the block sends the two sync bytes from the
// magic registers, then the 16-bit payload length low byte first, and seeds a
// reflected ieee crc-32 (all ones) over the two length bytes. Each payload item
// (cmd 1) passes its byte through and folds it into the crc; after the last counted
// byte the inverted crc follows, least significant byte first, with out_frame_end on
// its final byte. A zero-length start sends header and crc in one go (8 bytes). A
// payload byte with no open frame, or a start inside an open frame, gives one byte
// with out_error_code set and leaves the state alone. out_run_last marks the last
// byte caused by an item. Rate: an item is taken at the edge it arrives when the
// burst register is free, and its first byte shows in the cycle after; it then
// occupies the output burst register until all of its result bytes have left:
// 1 for a plain payload byte or an error, 4 for a start, 5 for the closing payload
// byte, 8 for an empty frame. The next item is taken in the same cycle the last byte
// of the previous one leaves, so payload bytes run at one per cycle unless stalled.
// Configuration writes go straight to the magic registers and must come while idle.
`include "serial_frame_builder_crc32_macros.svh"

module serial_frame_builder_crc32 (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration
  input  logic                          cfg_we,
  input  logic [sfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_wdata,
  // input items
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_cmd,
  input  logic [15:0]                   in_frame_length,
  input  logic [7:0]                    in_data_byte,
  // result items
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_byte,
  output logic                          out_frame_end,
  output logic [1:0]                    out_error_code,
  output logic                          out_run_last
);

  // sync byte registers
  logic [7:0]  magic_first_r;
  logic [7:0]  magic_second_r;

  // frame state
  logic        frame_open_r, frame_open_nxt;
  logic [15:0] bytes_left_r, bytes_left_nxt;
  logic [31:0] crc_r, crc_nxt;

  logic            accept;
  logic            burst_free;
  sfb_pkg::burst_t desc;

  // crc candidates: over the length field for a start, one step for a payload byte
  logic [31:0] crc_len;
  logic [31:0] crc_pay;
  logic [31:0] fin_len;
  logic [31:0] fin_pay;
  logic [15:0] left_dec;

  assign crc_len  = sfb_pkg::crc_byte(sfb_pkg::crc_byte(sfb_pkg::CRC_SEED,
                                                        in_frame_length[7:0]),
                                      in_frame_length[15:8]);
  assign crc_pay  = sfb_pkg::crc_byte(crc_r, in_data_byte);
  assign fin_len  = ~crc_len;
  assign fin_pay  = ~crc_pay;
  assign left_dec = bytes_left_r - 16'd1;

  // an item is taken whenever the burst register is empty or drains this cycle
  assign in_stall = !burst_free;
  assign accept   = in_valid && burst_free;

  // build the burst for the incoming item and the next frame state
  always_comb begin
    desc           = '0;
    frame_open_nxt = frame_open_r;
    bytes_left_nxt = bytes_left_r;
    crc_nxt        = crc_r;
    if (in_cmd == sfb_pkg::CMD_START) begin
      if (frame_open_r) begin
        // start inside a frame: flag it, frame goes on
        desc.err = sfb_pkg::ERR_START_IN_FRAME;
      end else begin
        desc.bytes[0] = magic_first_r;
        desc.bytes[1] = magic_second_r;
        desc.bytes[2] = in_frame_length[7:0];
        desc.bytes[3] = in_frame_length[15:8];
        crc_nxt       = crc_len;
        if (in_frame_length == 16'd0) begin
          // empty payload: trailer follows the header at once
          desc.bytes[4] = fin_len[7:0];
          desc.bytes[5] = fin_len[15:8];
          desc.bytes[6] = fin_len[23:16];
          desc.bytes[7] = fin_len[31:24];
          desc.last_idx = 3'd7;
          desc.trailer  = 1'b1;
        end else begin
          desc.last_idx  = 3'd3;
          frame_open_nxt = 1'b1;
          bytes_left_nxt = in_frame_length;
        end
      end
    end else begin
      if (!frame_open_r) begin
        // payload byte with no frame open
        desc.err = sfb_pkg::ERR_BYTE_OUTSIDE;
      end else begin
        desc.bytes[0]  = in_data_byte;
        crc_nxt        = crc_pay;
        bytes_left_nxt = left_dec;
        if (left_dec == 16'd0) begin
          // closing byte: append the inverted crc
          desc.bytes[1]  = fin_pay[7:0];
          desc.bytes[2]  = fin_pay[15:8];
          desc.bytes[3]  = fin_pay[23:16];
          desc.bytes[4]  = fin_pay[31:24];
          desc.last_idx  = 3'd4;
          desc.trailer   = 1'b1;
          frame_open_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_first_r  <= 8'd0;
      magic_second_r <= 8'd0;
      frame_open_r   <= 1'b0;
      bytes_left_r   <= 16'd0;
      crc_r          <= sfb_pkg::CRC_SEED;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sfb_pkg::REG_MAGIC_FIRST:  magic_first_r  <= cfg_wdata;
          sfb_pkg::REG_MAGIC_SECOND: magic_second_r <= cfg_wdata;
          default:                   magic_first_r  <= magic_first_r;
        endcase
      end
      if (accept) begin
        frame_open_r <= frame_open_nxt;
        bytes_left_r <= bytes_left_nxt;
        crc_r        <= crc_nxt;
      end
    end
  end

  // result side: one byte per cycle from the burst register while out_stall is low
  sfb_burst u_burst (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (accept),
    .desc           (desc),
    .free           (burst_free),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_frame_end  (out_frame_end),
    .out_error_code (out_error_code),
    .out_run_last   (out_run_last)
  );

  // count is zero exactly when no frame is open
  `SFB_ASSERT_IMPL(a_closed_count, clk, rst_n, !frame_open_r, bytes_left_r == 16'd0)
  `SFB_ASSERT_IMPL(a_open_count, clk, rst_n, frame_open_r, bytes_left_r != 16'd0)
  // a stray payload byte shows up as an error on the next cycle
  `SFB_ASSERT_NEXT(a_stray_byte, clk, rst_n,
                   accept && (in_cmd == sfb_pkg::CMD_PAYLOAD) && !frame_open_r,
                   out_valid && (out_error_code == sfb_pkg::ERR_BYTE_OUTSIDE))
  // the final crc byte always ends its item's run
  `SFB_ASSERT_IMPL(a_end_is_last, clk, rst_n, out_valid && out_frame_end, out_run_last)

endmodule

// File: dv/frame_check_pkg.sv
// scoreboard for the length-prefixed crc-32 frame builder
`timescale 1ns / 1ps

package frame_check_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic [1:0] err;
    logic       run_last;
  } frame_out_t;

  class frame_scoreboard;
    frame_out_t  expected_q[$];
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic        frame_open;
    logic [15:0] bytes_left;
    logic [31:0] crc;
    int          mismatches;

    function new();
      sync_first  = 8'h00;
      sync_second = 8'h00;
      frame_open  = 1'b0;
      bytes_left  = 16'h0000;
      crc         = sfb_pkg::CRC_SEED;
      mismatches  = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // reflected crc-32, lsb first, one byte
    function logic [31:0] crc_step(logic [31:0] c, logic [7:0] b);
      logic [31:0] r;
      r = c ^ {24'h0, b};
      repeat (8) r = r[0] ? ((r >> 1) ^ sfb_pkg::CRC_POLY) : (r >> 1);
      return r;
    endfunction

    function void emit(logic [7:0] data, logic frame_end, logic [1:0] err, logic run_last);
      frame_out_t e;
      e.data      = data;
      e.frame_end = frame_end;
      e.err       = err;
      e.run_last  = run_last;
      expected_q.push_back(e);
    endfunction

    // inverted crc, low byte first, closes the frame
    function void emit_trailer();
      logic [31:0] fin;
      fin = ~crc;
      for (int i = 0; i < 4; i++)
        emit(fin[8*i +: 8], i == 3, sfb_pkg::ERR_NONE, i == 3);
      frame_open = 1'b0;
      bytes_left = 16'h0000;
    endfunction

    function void note_config(logic [sfb_pkg::CFG_IDX_W-1:0] idx, logic [7:0] value);
      if (idx == sfb_pkg::REG_MAGIC_FIRST) sync_first = value;
      else if (idx == sfb_pkg::REG_MAGIC_SECOND) sync_second = value;
    endfunction

    function void note_item(logic cmd, logic [15:0] len, logic [7:0] data);
      if (cmd == sfb_pkg::CMD_START) begin
        if (frame_open) begin
          emit(8'h00, 1'b0, sfb_pkg::ERR_START_IN_FRAME, 1'b1);
        end else begin
          emit(sync_first, 1'b0, sfb_pkg::ERR_NONE, 1'b0);
          emit(sync_second, 1'b0, sfb_pkg::ERR_NONE, 1'b0);
          emit(len[7:0], 1'b0, sfb_pkg::ERR_NONE, 1'b0);
          emit(len[15:8], 1'b0, sfb_pkg::ERR_NONE, len != 16'h0000);
          crc = crc_step(crc_step(sfb_pkg::CRC_SEED, len[7:0]), len[15:8]);
          if (len == 16'h0000) begin
            emit_trailer();
          end else begin
            frame_open = 1'b1;
            bytes_left = len;
          end
        end
      end else begin
        if (!frame_open) begin
          emit(8'h00, 1'b0, sfb_pkg::ERR_BYTE_OUTSIDE, 1'b1);
        end else begin
          crc = crc_step(crc, data);
          bytes_left = bytes_left - 16'd1;
          emit(data, 1'b0, sfb_pkg::ERR_NONE, bytes_left != 16'h0000);
          if (bytes_left == 16'h0000) emit_trailer();
        end
      end
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 100) $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_result(logic [7:0] data, logic frame_end, logic [1:0] err, logic run_last);
      frame_out_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected byte %02h", data));
      end else begin
        e = expected_q.pop_front();
        if (data !== e.data)
          report($sformatf("out_byte %02h, wanted %02h", data, e.data));
        if (frame_end !== e.frame_end)
          report($sformatf("out_frame_end %b, wanted %b", frame_end, e.frame_end));
        if (err !== e.err)
          report($sformatf("out_error_code %0d, wanted %0d", err, e.err));
        if (run_last !== e.run_last)
          report($sformatf("out_run_last %b, wanted %b", run_last, e.run_last));
      end
    endtask
  endclass

endpackage

// File: dv/tb_top.sv
// top-level testbench for the length-prefixed crc-32 frame builder
`timescale 1ns / 1ps

module tb_top;

  // cycle ceiling: far above the run even if every item gave eight bytes under steady stalls
  localparam int unsigned CYCLE_LIMIT = 20_000;
  // worst burst is 8 bytes, so this covers anything still in flight
  localparam int unsigned SETTLE      = 20;
  localparam int unsigned HOLD_CYCLES = 80;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [sfb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                    cfg_wdata;
  logic                          in_valid;
  logic                          in_stall;
  logic                          in_cmd;
  logic [15:0]                   in_frame_length;
  logic [7:0]                    in_data_byte;
  logic                          out_valid;
  logic                          out_stall;
  logic [7:0]                    out_byte;
  logic                          out_frame_end;
  logic [1:0]                    out_error_code;
  logic                          out_run_last;

  frame_check_pkg::frame_scoreboard sb;
  int unsigned     cycle_count = 0;
  int unsigned     items_sent;
  // calm turns off random idling on both sides
  bit              calm;
  // request from the stimulus to the receiver for a long stall
  bit              hold_req;

  serial_frame_builder_crc32 i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_frame_length (in_frame_length),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_frame_end   (out_frame_end),
    .out_error_code  (out_error_code),
    .out_run_last    (out_run_last)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // every byte that leaves the block is checked at the edge that takes it
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_byte, out_frame_end, out_error_code, out_run_last);
  end

  // receiver: random stalls, or a long hold-off when asked for one
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 18);
      end
    end
  end

  // offer one item and hold it until the block takes it
  task automatic send_item(input logic cmd, input logic [15:0] len, input logic [7:0] data);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_frame_length <= len;
    in_data_byte    <= data;
    do @(posedge clk); while (in_stall);
    sb.note_item(cmd, len, data);
    items_sent++;
  endtask

  // start carries a random data byte, payload a random length: both are don't-cares
  task automatic send_start(input logic [15:0] len);
    send_item(sfb_pkg::CMD_START, len, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_payload(input logic [7:0] data);
    send_item(sfb_pkg::CMD_PAYLOAD, 16'($urandom_range(0, 65535)), data);
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // sender stays quiet until every expected byte is out, then lets the block settle
  task automatic wait_drained();
    drop_valid();
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // registers change only while the block is idle
  task automatic write_reg(input logic [sfb_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    sb.note_config(idx, value);
  endtask

  task automatic set_sync(input logic [7:0] first, input logic [7:0] second);
    wait_drained();
    write_reg(sfb_pkg::REG_MAGIC_FIRST, first);
    write_reg(sfb_pkg::REG_MAGIC_SECOND, second);
  endtask

  // mostly well-formed frames with random content, plus stray bytes and nested starts
  task automatic random_frame();
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_payload(8'($urandom_range(0, 255)));
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 15) len = 0;
      else if (pick < 75) len = $urandom_range(1, 6);
      else len = $urandom_range(7, 24);
      send_start(16'(len));
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) < 6) send_start(16'($urandom_range(0, 65535)));
        send_payload(8'($urandom_range(0, 255)));
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = sfb_pkg::REG_MAGIC_FIRST;
    cfg_wdata       = 8'h00;
    in_valid        = 1'b0;
    in_cmd          = sfb_pkg::CMD_START;
    in_frame_length = 16'h0000;
    in_data_byte    = 8'h00;
    out_stall       = 1'b0;
    calm            = 1'b0;
    hold_req        = 1'b0;
    items_sent      = 0;
    sb              = new();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: sync bytes at their reset value first
    send_payload(8'hFF);            // stray byte with nothing open
    send_start(16'h0000);           // empty frame, header and crc in one burst

    set_sync(8'hFF, 8'hFF);
    send_start(16'h0001);
    send_payload(8'h00);            // single byte closes the frame
    send_start(16'h0002);
    send_start(16'hFFFF);           // nested start, must be dropped
    send_payload(8'hFF);
    send_payload(8'h80);
    send_payload(8'hAA);            // frame already closed
    send_start(16'h0000);
    send_start(16'h0010);           // frame open for 16 bytes
    send_start(16'h0100);           // nested again
    for (int i = 0; i < 16; i++) send_payload(8'(i * 17));
    send_start(16'h0003);
    send_payload(8'h55);
    send_payload(8'hAA);
    send_payload(8'h01);

    // pressure: receiver holds off while the sender keeps offering a long frame
    set_sync(8'hA5, 8'h5A);
    hold_req = 1'b1;
    calm     = 1'b1;
    send_start(16'd20);
    for (int i = 0; i < 20; i++) send_payload(8'($urandom_range(0, 255)));
    calm = 1'b0;
    // and the sender pauses until the backlog is gone
    wait_drained();

    // random phases, each on its own sync setting
    set_sync(8'h00, 8'hFF);
    while (items_sent < 100) random_frame();
    set_sync(8'hFF, 8'h00);
    calm = 1'b1;                    // stretch with no idling at all
    while (items_sent < 120) random_frame();
    calm = 1'b0;
    set_sync(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    while (items_sent < 140) random_frame();
    send_payload(8'h3C);            // stray byte once the last frame is closed

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
